// ----- rtl/blmac_pkg.sv -----
`timescale 1ns / 1ps
package blmac_pkg;

	// Command codes carried by an input transfer.
	localparam logic CMD_BEAM   = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	// Configuration register indexes.
	localparam logic REG_DIMENSION  = 1'b0;
	localparam logic REG_NODE_COUNT = 1'b1;

	localparam logic [1:0] DIM_2D           = 2'd2;
	localparam logic [1:0] DIM_RESET        = 2'd3;
	localparam logic [6:0] NODE_COUNT_RESET = 7'd64;

	// Q0.32 constants: 1/pi, 3/(4 pi) and 2/5.
	localparam logic [63:0] INV_PI       = 64'd1367130551;
	localparam logic [63:0] K_SPH        = 64'd1025347913;
	localparam logic [63:0] K_TWO_FIFTHS = 64'd1717986918;

	localparam logic [47:0] MAX48 = {48{1'b1}};
	localparam logic [62:0] CAP62 = {1'b1, 62'b0};

	typedef struct packed {
		logic        command;
		logic        bad;
		logic [5:0]  first_node;
		logic [5:0]  second_node;
		logic [65:0] sum;
		logic [31:0] density;
		logic [31:0] area;
	} beam_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [47:0] sat_shr16(input logic [127:0] p);
		return (|p[127:64]) ? MAX48 : p[63:16];
	endfunction

	function automatic logic [47:0] sat_shr32(input logic [127:0] p);
		return (|p[127:80]) ? MAX48 : p[79:32];
	endfunction

	function automatic logic [62:0] cap62_shr16(input logic [127:0] p);
		logic [62:0] v;
		v = p[78:16];
		if ((|p[127:79]) || (v[62] && (|v[61:0])))
			return CAP62;
		return v;
	endfunction

	function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [48:0] b);
		logic [49:0] s;
		s = {2'b0, a} + {1'b0, b};
		return (|s[49:48]) ? MAX48 : s[47:0];
	endfunction

endpackage

// ----- rtl/blmac_mul.sv -----
`timescale 1ns / 1ps
module blmac_mul import blmac_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] prod
);

	// 64x64 product from four 32x32 partial products, one per cycle.
	logic         run_q;
	logic         done_q;
	logic [2:0]   ph_q;
	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [63:0]  pp_s1;
	logic [1:0]   sh_s1;
	logic [127:0] acc_q;
	logic [31:0]  a_half;
	logic [31:0]  b_half;
	logic [127:0] pp_ext;

	assign a_half = ph_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_half = ph_q[0] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		unique case (sh_s1)
			2'd0:    pp_ext = {64'b0, pp_s1};
			2'd1:    pp_ext = {32'b0, pp_s1, 32'b0};
			default: pp_ext = {pp_s1, 64'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= '0;
			a_q    <= '0;
			b_q    <= '0;
			pp_s1  <= '0;
			sh_s1  <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				ph_q  <= '0;
				a_q   <= a;
				b_q   <= b;
				acc_q <= '0;
			end else if (run_q) begin
				if (ph_q != 3'd4) begin
					pp_s1 <= a_half * b_half;
					sh_s1 <= {1'b0, ph_q[1]} + {1'b0, ph_q[0]};
				end
				if (ph_q != 3'd0)
					acc_q <= acc_q + pp_ext;
				if (ph_q == 3'd4) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				ph_q <= ph_q + 3'd1;
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ----- rtl/blmac_root.sv -----
`timescale 1ns / 1ps
module blmac_root import blmac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        cube,
	input  logic [79:0] op,
	output logic        done,
	output logic [33:0] root
);

	// Digit-recurrence integer root: two operand bits per step for the square
	// root, three per step for the cube root. No multiplier is needed because
	// y squared is kept up to date alongside y.
	logic        run_q;
	logic        cube_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [80:0] sr_q;
	logic [63:0] rem_q;
	logic [33:0] y_q;
	logic [53:0] y2_q;

	logic [34:0] yd;
	logic [55:0] y2d;
	logic [63:0] remd;
	logic [55:0] t;
	logic [63:0] b_sq;
	logic [63:0] b_cu;
	logic [63:0] bb;
	logic        take;

	always_comb begin
		yd   = {y_q, 1'b0};
		y2d  = {y2_q, 2'b00};
		remd = cube_q ? {rem_q[60:0], sr_q[80:78]} : {rem_q[61:0], sr_q[80:79]};
		b_sq = {28'b0, yd, 1'b1};
		t    = y2d + {21'b0, yd};
		b_cu = {8'b0, t} + {7'b0, t, 1'b0} + 64'd1;
		bb   = cube_q ? b_cu : b_sq;
		take = (remd >= bb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cube_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			sr_q   <= '0;
			rem_q  <= '0;
			y_q    <= '0;
			y2_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				cube_q <= cube;
				cnt_q  <= cube ? 6'd27 : 6'd34;
				sr_q   <= cube ? {1'b0, op} : {op[67:0], 13'b0};
				rem_q  <= '0;
				y_q    <= '0;
				y2_q   <= '0;
			end else if (run_q) begin
				sr_q  <= cube_q ? {sr_q[77:0], 3'b0} : {sr_q[78:0], 2'b0};
				rem_q <= take ? (remd - bb) : remd;
				y_q   <= yd[33:0] + {33'b0, take};
				y2_q  <= y2d[53:0] + (take ? {18'b0, yd, 1'b1} : 54'd0);
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = y_q;

endmodule

// ----- rtl/blmac_front.sv -----
`timescale 1ns / 1ps
module blmac_front import blmac_pkg::*; #(
	parameter int LIM_W = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              hold,
	input  logic              command,
	input  logic [5:0]        first_node,
	input  logic [5:0]        second_node,
	input  logic [31:0]       first_x,
	input  logic [31:0]       first_y,
	input  logic [31:0]       first_z,
	input  logic [31:0]       second_x,
	input  logic [31:0]       second_y,
	input  logic [31:0]       second_z,
	input  logic [31:0]       density,
	input  logic [31:0]       area,
	input  logic [1:0]        dimension,
	input  logic [LIM_W-1:0]  lim,
	input  q_stat_t           q_stat,
	output logic              busy,
	output logic              push,
	output beam_entry_t       entry
);

	typedef enum logic [1:0] {F_IDLE, F_CALC, F_PUSH} state_t;

	state_t      state_q;
	logic [2:0]  step_q;
	logic        v1_s1;
	logic        v2_s2;
	logic        cmd_q;
	logic        bad_q;
	logic [5:0]  n1_q;
	logic [5:0]  n2_q;
	logic [31:0] c_q [6];
	logic [31:0] density_q;
	logic [31:0] area_q;
	logic [31:0] mag_s1;
	logic [63:0] sq_s2;
	logic [65:0] sum_q;

	logic        accept;
	logic        bad;
	logic [2:0]  naxes;
	logic [31:0] pa;
	logic [31:0] pb;
	logic [32:0] diff;
	logic [32:0] mag;

	assign busy   = (state_q != F_IDLE) || hold;
	assign accept = start && !busy;
	assign push   = (state_q == F_PUSH) && !q_stat.full;
	assign naxes  = (dimension == DIM_2D) ? 3'd2 : 3'd3;
	assign bad    = (command == CMD_BEAM) &&
		((32'(first_node) >= 32'(lim)) || (32'(second_node) >= 32'(lim)));

	always_comb begin
		unique case (step_q[1:0])
			2'd0: begin
				pa = c_q[0];
				pb = c_q[3];
			end
			2'd1: begin
				pa = c_q[1];
				pb = c_q[4];
			end
			default: begin
				pa = c_q[2];
				pb = c_q[5];
			end
		endcase
		diff = {pa[31], pa} - {pb[31], pb};
		mag  = diff[32] ? (33'd0 - diff) : diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
			v1_s1   <= 1'b0;
			v2_s2   <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						step_q <= '0;
						v1_s1  <= 1'b0;
						v2_s2  <= 1'b0;
						if (command == CMD_FINISH || bad)
							state_q <= F_PUSH;
						else
							state_q <= F_CALC;
					end
				end
				F_CALC: begin
					v1_s1  <= (step_q < naxes);
					v2_s2  <= v1_s1;
					step_q <= step_q + 3'd1;
					if (step_q == naxes + 3'd1)
						state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Item fields and the sum of squared coordinate differences.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= command;
			bad_q     <= bad;
			n1_q      <= first_node;
			n2_q      <= second_node;
			c_q[0]    <= first_x;
			c_q[1]    <= first_y;
			c_q[2]    <= first_z;
			c_q[3]    <= second_x;
			c_q[4]    <= second_y;
			c_q[5]    <= second_z;
			density_q <= density;
			area_q    <= area;
			sum_q     <= '0;
		end else if (state_q == F_CALC && v2_s2) begin
			sum_q <= sum_q + {2'b0, sq_s2};
		end
		mag_s1 <= mag[31:0];
		sq_s2  <= mag_s1 * mag_s1;
	end

	assign entry = '{
		command:     cmd_q,
		bad:         bad_q,
		first_node:  n1_q,
		second_node: n2_q,
		sum:         sum_q,
		density:     density_q,
		area:        area_q
	};

endmodule

// ----- rtl/blmac_queue.sv -----
`timescale 1ns / 1ps
module blmac_queue import blmac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  beam_entry_t entry_in,
	input  logic        pop,
	output beam_entry_t entry_out,
	output q_stat_t     q_stat
);

	// Two-entry queue between the front and the back.
	beam_entry_t slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= entry_in;
	end

	assign entry_out    = slot_q[rd_ptr_q];
	assign q_stat.full  = (count_q == 2'd2);
	assign q_stat.empty = (count_q == 2'd0);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.full && !pop) |=> (count_q == 2'd2))
		else $error("full queue lost an entry without a read");
`endif

endmodule

// ----- rtl/blmac_back.sv -----
`timescale 1ns / 1ps
module blmac_back import blmac_pkg::*; #(
	parameter int MAX_NODES = 64,
	parameter int CW        = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    dimension,
	input  logic [CW-1:0] lim,
	input  q_stat_t       q_stat,
	input  beam_entry_t   head,
	output logic          pop,
	output logic          init_busy,
	output logic          result_strobe,
	output logic [5:0]    node_index,
	output logic [47:0]   node_mass,
	output logic [47:0]   node_inertia,
	output logic          error_seen,
	output logic          last
);

	localparam int AW = $clog2(MAX_NODES);

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_SQRT, S_VOL, S_MASS, S_RD1, S_WR1, S_RD2, S_WR2,
		S_WALK_RD, S_WALK_GOT, S_C, S_R, S_RR, S_P, S_I, S_CLR
	} state_t;

	state_t        state_q;
	logic [CW-1:0] i_q;
	logic          err_q;
	beam_entry_t   ent_q;
	logic [47:0]   m_q;
	logic [47:0]   v_q;
	logic          mul_go_q;
	logic [63:0]   mul_a_q;
	logic [63:0]   mul_b_q;
	logic          root_go_q;
	logic          root_cube_q;
	logic [79:0]   root_op_q;
	logic          strobe_q;
	logic [5:0]    index_q;
	logic [47:0]   mass_q;
	logic [47:0]   inertia_q;
	logic          error_q;
	logic          last_q;

	logic          mul_done;
	logic [127:0]  mul_prod;
	logic          root_done;
	logic [33:0]   root_val;

	logic [95:0]   mem [MAX_NODES];
	logic [95:0]   rd_data_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	logic [95:0]   mem_wdata;

	logic          is_2d;
	logic          same;
	logic [AW+5:0] n1_ext;
	logic [AW+5:0] n2_ext;
	logic [AW-1:0] n1_a;
	logic [AW-1:0] n2_a;
	logic [AW-1:0] i_a;
	logic [CW+5:0] i_ext;
	logic [CW:0]   nxt;
	logic [48:0]   add_m;
	logic [48:0]   add_v;
	logic [95:0]   upd;

	blmac_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	blmac_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_go_q),
		.cube   (root_cube_q),
		.op     (root_op_q),
		.done   (root_done),
		.root   (root_val)
	);

	assign is_2d  = (dimension == DIM_2D);
	assign same   = (ent_q.first_node == ent_q.second_node);
	assign n1_ext = {{AW{1'b0}}, ent_q.first_node};
	assign n2_ext = {{AW{1'b0}}, ent_q.second_node};
	assign n1_a   = n1_ext[AW-1:0];
	assign n2_a   = n2_ext[AW-1:0];
	assign i_a    = i_q[AW-1:0];
	assign i_ext  = {6'b0, i_q};
	assign nxt    = {1'b0, i_q} + {{CW{1'b0}}, 1'b1};
	assign pop    = (state_q == S_IDLE) && !q_stat.empty;

	// A beam whose two ends coincide adds both halves in one update.
	assign add_m = same ? {1'b0, m_q[47:1], 1'b0} : {2'b0, m_q[47:1]};
	assign add_v = same ? {1'b0, v_q[47:1], 1'b0} : {2'b0, v_q[47:1]};
	assign upd   = {sat_add48(rd_data_q[95:48], add_m), sat_add48(rd_data_q[47:0], add_v)};

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = n1_a;
		mem_raddr = n1_a;
		mem_wdata = '0;
		unique case (state_q)
			S_INIT, S_CLR, S_WALK_GOT: begin
				mem_we    = 1'b1;
				mem_waddr = i_a;
			end
			S_WALK_RD: mem_raddr = i_a;
			S_WR1: begin
				mem_we    = 1'b1;
				mem_wdata = upd;
			end
			S_RD2: mem_raddr = n2_a;
			S_WR2: begin
				mem_we    = 1'b1;
				mem_waddr = n2_a;
				mem_wdata = upd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_data_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			i_q         <= '0;
			err_q       <= 1'b0;
			ent_q       <= '0;
			m_q         <= '0;
			v_q         <= '0;
			mul_go_q    <= 1'b0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			root_go_q   <= 1'b0;
			root_cube_q <= 1'b0;
			root_op_q   <= '0;
			strobe_q    <= 1'b0;
			index_q     <= '0;
			mass_q      <= '0;
			inertia_q   <= '0;
			error_q     <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			mul_go_q  <= 1'b0;
			root_go_q <= 1'b0;
			strobe_q  <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					if (i_q == CW'(MAX_NODES - 1))
						state_q <= S_IDLE;
					else
						i_q <= nxt[CW-1:0];
				end
				S_IDLE: begin
					if (pop) begin
						ent_q <= head;
						if (head.command == CMD_FINISH) begin
							i_q <= '0;
							state_q <= (lim == '0) ? S_CLR : S_WALK_RD;
						end else if (head.bad) begin
							err_q <= 1'b1;
						end else begin
							root_go_q   <= 1'b1;
							root_cube_q <= 1'b0;
							root_op_q   <= {14'b0, head.sum};
							state_q     <= S_SQRT;
						end
					end
				end
				S_SQRT: begin
					if (root_done) begin
						mul_go_q <= 1'b1;
						mul_a_q  <= {30'b0, root_val};
						mul_b_q  <= {32'b0, ent_q.area};
						state_q  <= S_VOL;
					end
				end
				S_VOL: begin
					if (mul_done) begin
						v_q      <= sat_shr16(mul_prod);
						mul_go_q <= 1'b1;
						mul_a_q  <= {16'b0, sat_shr16(mul_prod)};
						mul_b_q  <= {32'b0, ent_q.density};
						state_q  <= S_MASS;
					end
				end
				S_MASS: begin
					if (mul_done) begin
						m_q     <= sat_shr16(mul_prod);
						state_q <= S_RD1;
					end
				end
				S_RD1: state_q <= S_WR1;
				S_WR1: state_q <= same ? S_IDLE : S_RD2;
				S_RD2: state_q <= S_WR2;
				S_WR2: state_q <= S_IDLE;
				S_WALK_RD: state_q <= S_WALK_GOT;
				S_WALK_GOT: begin
					m_q      <= rd_data_q[95:48];
					v_q      <= rd_data_q[47:0];
					mul_go_q <= 1'b1;
					if (is_2d) begin
						mul_a_q <= {16'b0, rd_data_q[95:48]};
						mul_b_q <= {16'b0, rd_data_q[47:0]};
						state_q <= S_P;
					end else begin
						mul_a_q <= {16'b0, rd_data_q[47:0]};
						mul_b_q <= K_SPH;
						state_q <= S_C;
					end
				end
				S_C: begin
					if (mul_done) begin
						root_go_q   <= 1'b1;
						root_cube_q <= 1'b1;
						root_op_q   <= {sat_shr32(mul_prod), 32'b0};
						state_q     <= S_R;
					end
				end
				S_R: begin
					if (root_done) begin
						mul_go_q <= 1'b1;
						mul_a_q  <= {37'b0, root_val[26:0]};
						mul_b_q  <= {37'b0, root_val[26:0]};
						state_q  <= S_RR;
					end
				end
				S_RR: begin
					if (mul_done) begin
						mul_go_q <= 1'b1;
						mul_a_q  <= {16'b0, m_q};
						mul_b_q  <= {26'b0, mul_prod[53:16]};
						state_q  <= S_P;
					end
				end
				S_P: begin
					if (mul_done) begin
						mul_go_q <= 1'b1;
						mul_a_q  <= {1'b0, cap62_shr16(mul_prod)};
						mul_b_q  <= is_2d ? INV_PI : K_TWO_FIFTHS;
						state_q  <= S_I;
					end
				end
				S_I: begin
					if (mul_done) begin
						strobe_q  <= 1'b1;
						index_q   <= i_ext[5:0];
						mass_q    <= m_q;
						inertia_q <= sat_shr32(mul_prod);
						error_q   <= err_q;
						last_q    <= (nxt == {1'b0, lim});
						if (nxt < {1'b0, lim}) begin
							i_q     <= nxt[CW-1:0];
							state_q <= S_WALK_RD;
						end else if (nxt < (CW + 1)'(MAX_NODES)) begin
							i_q     <= nxt[CW-1:0];
							state_q <= S_CLR;
						end else begin
							err_q   <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				S_CLR: begin
					if (i_q == CW'(MAX_NODES - 1)) begin
						err_q   <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						i_q <= nxt[CW-1:0];
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign init_busy     = (state_q == S_INIT);
	assign result_strobe = strobe_q;
	assign node_index    = index_q;
	assign node_mass     = mass_q;
	assign node_inertia  = inertia_q;
	assign error_seen    = error_q;
	assign last          = last_q;

endmodule

// ----- rtl/beam_lumped_mass_accumulator_top.sv -----
`timescale 1ns / 1ps
// Lumped-mass accumulator for two-node beams. A beam transfer (command 0) is
// accepted when start is high and busy is low; the front computes the sum of
// squared coordinate differences and hands the item to a two-entry queue, so
// it can take the next transfer while the back is still working. The back
// takes the beam length with a bit-serial square root, forms volume and mass
// with a shared multiplier (each product built from 32x32 partial products)
// and adds half of each to both end nodes with a read-modify-write of a
// one-write, one-read node memory. A finish transfer (command 1) walks every
// node of the memory: each node below the active node count is processed
// with the multiplier alone in 2D and with a cube root plus four products in
// 3D, then produces one result, shown for exactly one clock cycle with
// result_strobe high; the receiver cannot stall and must take it in that
// cycle. Nodes at or above the active count are cleared at one per cycle,
// and last marks the result for the final node. After reset the block clears
// its node memory and holds busy high while it does so. Beams naming a node
// at or above min(node_count, MAX_NODES) are dropped and set error_seen on
// every result of the next finish. Configuration is written through
// cfg_wr_en, cfg_index and cfg_wdata; the user must write it only while the
// block is idle, as the block itself does not enforce this.
module beam_lumped_mass_accumulator_top import blmac_pkg::*; #(
	parameter int MAX_NODES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [0:0]  cfg_index,
	input  logic [6:0]  cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [5:0]  first_node,
	input  logic [5:0]  second_node,
	input  logic [31:0] first_x,
	input  logic [31:0] first_y,
	input  logic [31:0] first_z,
	input  logic [31:0] second_x,
	input  logic [31:0] second_y,
	input  logic [31:0] second_z,
	input  logic [31:0] density,
	input  logic [31:0] area,
	output logic        result_strobe,
	output logic [5:0]  node_index,
	output logic [47:0] node_mass,
	output logic [47:0] node_inertia,
	output logic        error_seen,
	output logic        last
);

	// Wide enough to hold the node count itself.
	localparam int CW = $clog2(MAX_NODES + 1);

	logic [1:0]    dimension_q;
	logic [6:0]    node_count_q;
	logic [CW-1:0] lim;

	logic          init_busy;
	logic          push;
	logic          pop;
	beam_entry_t   front_entry;
	beam_entry_t   head;
	q_stat_t       q_stat;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dimension_q  <= DIM_RESET;
			node_count_q <= NODE_COUNT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DIMENSION:  dimension_q  <= cfg_wdata[1:0];
				REG_NODE_COUNT: node_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The active node count never exceeds the size of the node memory.
	assign lim = (32'(node_count_q) < MAX_NODES) ? CW'(node_count_q) : CW'(MAX_NODES);

	blmac_front #(
		.LIM_W (CW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.hold        (init_busy),
		.command     (command),
		.first_node  (first_node),
		.second_node (second_node),
		.first_x     (first_x),
		.first_y     (first_y),
		.first_z     (first_z),
		.second_x    (second_x),
		.second_y    (second_y),
		.second_z    (second_z),
		.density     (density),
		.area        (area),
		.dimension   (dimension_q),
		.lim         (lim),
		.q_stat      (q_stat),
		.busy        (busy),
		.push        (push),
		.entry       (front_entry)
	);

	blmac_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.entry_in  (front_entry),
		.pop       (pop),
		.entry_out (head),
		.q_stat    (q_stat)
	);

	blmac_back #(
		.MAX_NODES (MAX_NODES),
		.CW        (CW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.dimension     (dimension_q),
		.lim           (lim),
		.q_stat        (q_stat),
		.head          (head),
		.pop           (pop),
		.init_busy     (init_busy),
		.result_strobe (result_strobe),
		.node_index    (node_index),
		.node_mass     (node_mass),
		.node_inertia  (node_inertia),
		.error_seen    (error_seen),
		.last          (last)
	);

`ifndef SYNTHESIS
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("front did not go busy after an accepted transfer");
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last) |=> !result_strobe)
		else $error("result directly after the final node");
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (32'(node_index) < 32'(lim)))
		else $error("result for a node outside the active count");
`endif

endmodule
